// ===== sv/tpc_pkg.sv =====
// ----------------------------------------------------------------------------
// Triangle plane clip: shared types and constants
// Widths of the distance, cut and divider datapaths, the clip mode codes,
// the configuration register indexes and the words carried down the divider.
// ----------------------------------------------------------------------------
package tpc_pkg;

	localparam int COORD_W   = 32;
	localparam int NORM_W    = 18;
	localparam int DIFF_W    = COORD_W + 1;
	localparam int MULT_W    = DIFF_W + NORM_W;
	localparam int D_W       = 52;
	localparam int MAG_W     = COORD_W;
	localparam int NUM_W     = 51;
	localparam int NUM_LO_W  = 26;
	localparam int NUM_HI_W  = NUM_W - NUM_LO_W;
	localparam int DEN_W     = 52;
	localparam int PROD_W    = MAG_W + NUM_W;
	localparam int Q_W       = MAG_W;
	localparam int DIV_STEPS = Q_W;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = COORD_W;

	localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
	localparam logic signed [NORM_W-1:0] NORMAL_Z_RST = NORM_W'(65536);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PLANE_PX = 3'd0,
		CFG_PLANE_PY = 3'd1,
		CFG_PLANE_PZ = 3'd2,
		CFG_NORMAL_X = 3'd3,
		CFG_NORMAL_Y = 3'd4,
		CFG_NORMAL_Z = 3'd5
	} cfg_reg_t;

	// Encoded as the number of corners on the inner side of the plane.
	typedef enum logic [1:0] {
		CLIP_NONE = 2'd0,
		CLIP_ONE  = 2'd1,
		CLIP_TWO  = 2'd2,
		CLIP_ALL  = 2'd3
	} mode_t;

	typedef logic [2:0][COORD_W-1:0] vec_t;

	typedef struct packed {
		mode_t                  mode;
		vec_t [2:0]             w;
		logic [1:0][2:0]        neg;
		logic [1:0][DEN_W-1:0]  den;
	} side_t;

	typedef struct packed {
		side_t                       side;
		logic [1:0][2:0][DEN_W-1:0]  rem;
		logic [1:0][2:0][Q_W-1:0]    quo;
	} div_t;

endpackage

// ===== sv/tpc_in_if.sv =====
// ----------------------------------------------------------------------------
// Triangle plane clip: input triangle channel
// Valid/ready channel carrying the three corners of one triangle.
// ----------------------------------------------------------------------------
interface tpc_in_if;
	logic valid;
	logic ready;
	logic signed [tpc_pkg::COORD_W-1:0] a_x;
	logic signed [tpc_pkg::COORD_W-1:0] a_y;
	logic signed [tpc_pkg::COORD_W-1:0] a_z;
	logic signed [tpc_pkg::COORD_W-1:0] b_x;
	logic signed [tpc_pkg::COORD_W-1:0] b_y;
	logic signed [tpc_pkg::COORD_W-1:0] b_z;
	logic signed [tpc_pkg::COORD_W-1:0] c_x;
	logic signed [tpc_pkg::COORD_W-1:0] c_y;
	logic signed [tpc_pkg::COORD_W-1:0] c_z;

	modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
		input ready);
	modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
		output ready);
endinterface

// ===== sv/tpc_out_if.sv =====
// ----------------------------------------------------------------------------
// Triangle plane clip: output triangle channel
// Valid/ready channel carrying one clipped triangle and the end-of-run flag.
// ----------------------------------------------------------------------------
interface tpc_out_if;
	logic valid;
	logic ready;
	logic signed [tpc_pkg::COORD_W-1:0] r0_x;
	logic signed [tpc_pkg::COORD_W-1:0] r0_y;
	logic signed [tpc_pkg::COORD_W-1:0] r0_z;
	logic signed [tpc_pkg::COORD_W-1:0] r1_x;
	logic signed [tpc_pkg::COORD_W-1:0] r1_y;
	logic signed [tpc_pkg::COORD_W-1:0] r1_z;
	logic signed [tpc_pkg::COORD_W-1:0] r2_x;
	logic signed [tpc_pkg::COORD_W-1:0] r2_y;
	logic signed [tpc_pkg::COORD_W-1:0] r2_z;
	logic last_of_run;

	modport source (output valid, r0_x, r0_y, r0_z, r1_x, r1_y, r1_z,
		r2_x, r2_y, r2_z, last_of_run, input ready);
	modport sink (input valid, r0_x, r0_y, r0_z, r1_x, r1_y, r1_z,
		r2_x, r2_y, r2_z, last_of_run, output ready);
endinterface

// ===== sv/tpc_div_step.sv =====
// ----------------------------------------------------------------------------
// Triangle plane clip: divider step
// One restoring division step for all six cut lanes, producing one quotient
// bit per lane, with the side data carried alongside.
// ----------------------------------------------------------------------------
module tpc_div_step (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           up_valid,
	input  tpc_pkg::div_t  up_word,
	output logic           dn_valid,
	output tpc_pkg::div_t  dn_word
);

	tpc_pkg::div_t step;
	logic [tpc_pkg::DEN_W:0] trial [2][3];
	logic [tpc_pkg::DEN_W:0] dsor [2];

	always_comb begin
		step = up_word;
		for (int e = 0; e < 2; e++) begin
			dsor[e] = {1'b0, up_word.side.den[e]};
			for (int k = 0; k < 3; k++) begin
				trial[e][k] = {up_word.rem[e][k], up_word.quo[e][k][tpc_pkg::Q_W-1]};
				if (trial[e][k] >= dsor[e]) begin
					step.rem[e][k] = tpc_pkg::DEN_W'(trial[e][k] - dsor[e]);
					step.quo[e][k] = {up_word.quo[e][k][tpc_pkg::Q_W-2:0], 1'b1};
				end else begin
					step.rem[e][k] = trial[e][k][tpc_pkg::DEN_W-1:0];
					step.quo[e][k] = {up_word.quo[e][k][tpc_pkg::Q_W-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dn_valid <= 1'b0;
		end else if (en) begin
			dn_valid <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dn_word <= step;
		end
	end

endmodule

// ===== sv/triangle_plane_clip_core.sv =====
// ----------------------------------------------------------------------------
// Triangle plane clip core
// Keeps the part of each triangle strictly on the negative side of the
// configured plane and sends it out as zero, one or three triangles.
//
//   channel   dir  handshake       payload
//   tri_in    in   valid/ready     a_x..c_z, Q16.16 corners
//   tri_out   out  valid/ready     r0_x..r2_z, last_of_run
//   cfg       in   cfg_we          cfg_idx, cfg_data
//
// From acceptance to the first output word a triangle passes the distance and
// cut set-up stages, 32 divider steps, the cut register and the output stage.
// A triangle giving no result sends no word; the output stage sends one word a
// cycle while tri_out.ready is high, taking no new result until the last has gone.
// Reset clears all valid bits and loads the reset plane; no clearing pass.
// A stalled output word freezes the whole pipeline, bubbles included.
// ----------------------------------------------------------------------------
module triangle_plane_clip_core (
	input  logic                              clk,
	input  logic                              arst_n,
	tpc_in_if.sink                            tri_in,
	tpc_out_if.source                         tri_out,
	input  logic                              cfg_we,
	input  logic [tpc_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [tpc_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int CW = tpc_pkg::COORD_W;

	logic signed [CW-1:0] plane_q [3];
	logic signed [tpc_pkg::NORM_W-1:0] normal_q [3];

	logic en;

	tpc_pkg::vec_t [2:0] vin;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	tpc_pkg::vec_t [2:0] v_s1, v_s2, v_s3;
	logic signed [tpc_pkg::DIFF_W-1:0] diff_s1 [3][3];
	logic signed [tpc_pkg::MULT_W-1:0] prod_s2 [3][3];
	logic signed [tpc_pkg::D_W-1:0] d_s3 [3];

	logic [2:0] inner;
	logic [1:0] c_in, c_out, o0, o1, i0, i1;
	logic signed [tpc_pkg::DIFF_W-1:0] msum [3];
	logic signed [tpc_pkg::DIFF_W-1:0] mrnd [3];
	tpc_pkg::mode_t mode_c;
	tpc_pkg::vec_t [2:0] w_c;
	tpc_pkg::vec_t [1:0] p2_c;
	logic signed [tpc_pkg::D_W-1:0] d1_c [2];
	logic signed [tpc_pkg::D_W-1:0] d2_c [2];

	tpc_pkg::mode_t mode_s4;
	tpc_pkg::vec_t [2:0] w_s4;
	tpc_pkg::vec_t [1:0] p2_s4;
	logic signed [tpc_pkg::D_W-1:0] d1_s4 [2];
	logic signed [tpc_pkg::D_W-1:0] d2_s4 [2];

	logic signed [tpc_pkg::DIFF_W-1:0] dk_c [2][3];
	tpc_pkg::side_t side_c;
	tpc_pkg::side_t side_s5, side_s6;
	logic [tpc_pkg::MAG_W-1:0] mag_s5 [2][3];
	logic [tpc_pkg::NUM_W-1:0] num_s5 [2];
	logic [tpc_pkg::MAG_W+tpc_pkg::NUM_LO_W-1:0] pp_lo_s6 [2][3];
	logic [tpc_pkg::MAG_W+tpc_pkg::NUM_HI_W-1:0] pp_hi_s6 [2][3];
	logic [tpc_pkg::PROD_W-1:0] prod_c [2][3];
	tpc_pkg::div_t word_s7;

	logic dv_valid [tpc_pkg::DIV_STEPS+1];
	tpc_pkg::div_t dv_word [tpc_pkg::DIV_STEPS+1];

	tpc_pkg::div_t fin;
	logic signed [CW+1:0] csum [2][3];
	tpc_pkg::vec_t [1:0] cut_c;
	logic valid_s40;
	tpc_pkg::side_t side_s40;
	tpc_pkg::vec_t [1:0] cut_s40;

	logic out_valid_q;
	logic [1:0] out_cnt_q;
	tpc_pkg::mode_t out_mode_q;
	tpc_pkg::vec_t [2:0] out_w_q;
	tpc_pkg::vec_t [1:0] out_e_q;
	logic out_last;
	tpc_pkg::vec_t r0, r1, r2;

	function automatic logic [1:0] nxt(input logic [1:0] i);
		return (i == 2'd2) ? 2'd0 : i + 2'd1;
	endfunction

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q[0] <= '0;
			plane_q[1] <= '0;
			plane_q[2] <= '0;
			normal_q[0] <= '0;
			normal_q[1] <= '0;
			normal_q[2] <= tpc_pkg::NORMAL_Z_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				tpc_pkg::CFG_PLANE_PX: plane_q[0] <= cfg_data;
				tpc_pkg::CFG_PLANE_PY: plane_q[1] <= cfg_data;
				tpc_pkg::CFG_PLANE_PZ: plane_q[2] <= cfg_data;
				tpc_pkg::CFG_NORMAL_X: normal_q[0] <= cfg_data[tpc_pkg::NORM_W-1:0];
				tpc_pkg::CFG_NORMAL_Y: normal_q[1] <= cfg_data[tpc_pkg::NORM_W-1:0];
				tpc_pkg::CFG_NORMAL_Z: normal_q[2] <= cfg_data[tpc_pkg::NORM_W-1:0];
				default: ;
			endcase
		end
	end

	assign en = !out_valid_q || (tri_out.ready && out_last);
	assign tri_in.ready = en;

	assign vin[0] = {tri_in.a_z, tri_in.a_y, tri_in.a_x};
	assign vin[1] = {tri_in.b_z, tri_in.b_y, tri_in.b_x};
	assign vin[2] = {tri_in.c_z, tri_in.c_y, tri_in.c_x};

	// Classification of the corners, choice of the two cut edges and the midpoint.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			inner[i] = d_s3[i][tpc_pkg::D_W-1];
		end
		c_in = 2'd0;
		c_out = 2'd0;
		for (int i = 0; i < 3; i++) begin
			if (inner[i]) begin
				c_in = 2'(i);
			end else begin
				c_out = 2'(i);
			end
		end
		o0 = nxt(c_in);
		o1 = nxt(o0);
		i1 = nxt(c_out);
		i0 = nxt(i1);
		mode_c = tpc_pkg::mode_t'(2'($countones(inner)));
		for (int k = 0; k < 3; k++) begin
			msum[k] = $signed({v_s3[i0][k][CW-1], v_s3[i0][k]})
				+ $signed({v_s3[i1][k][CW-1], v_s3[i1][k]});
			mrnd[k] = msum[k] + $signed({{(tpc_pkg::DIFF_W-1){1'b0}},
				msum[k][tpc_pkg::DIFF_W-1]});
		end
		w_c = v_s3;
		p2_c[0] = v_s3[0];
		p2_c[1] = v_s3[0];
		d1_c[0] = d_s3[0];
		d1_c[1] = d_s3[0];
		d2_c[0] = d_s3[0];
		d2_c[1] = d_s3[0];
		unique case (mode_c)
			tpc_pkg::CLIP_ONE: begin
				w_c[0] = v_s3[c_in];
				w_c[1] = v_s3[c_in];
				w_c[2] = v_s3[c_in];
				p2_c[0] = v_s3[o0];
				p2_c[1] = v_s3[o1];
				d1_c[0] = d_s3[c_in];
				d1_c[1] = d_s3[c_in];
				d2_c[0] = d_s3[o0];
				d2_c[1] = d_s3[o1];
			end
			tpc_pkg::CLIP_TWO: begin
				w_c[0] = v_s3[i0];
				for (int k = 0; k < 3; k++) begin
					w_c[1][k] = mrnd[k][tpc_pkg::DIFF_W-1:1];
				end
				w_c[2] = v_s3[i1];
				p2_c[0] = v_s3[c_out];
				p2_c[1] = v_s3[c_out];
				d1_c[0] = d_s3[i0];
				d1_c[1] = d_s3[i1];
				d2_c[0] = d_s3[c_out];
				d2_c[1] = d_s3[c_out];
			end
			default: ;
		endcase
	end

	// Edge deltas, their magnitudes and the cut fraction terms.
	always_comb begin
		side_c.mode = mode_s4;
		side_c.w = w_s4;
		for (int e = 0; e < 2; e++) begin
			side_c.den[e] = tpc_pkg::DEN_W'(d2_s4[e] - d1_s4[e]);
			for (int k = 0; k < 3; k++) begin
				dk_c[e][k] = $signed({p2_s4[e][k][CW-1], p2_s4[e][k]})
					- $signed({w_s4[2*e][k][CW-1], w_s4[2*e][k]});
				side_c.neg[e][k] = dk_c[e][k][tpc_pkg::DIFF_W-1];
			end
		end
	end

	always_comb begin
		for (int e = 0; e < 2; e++) begin
			for (int k = 0; k < 3; k++) begin
				prod_c[e][k] = (tpc_pkg::PROD_W'(pp_hi_s6[e][k]) << tpc_pkg::NUM_LO_W)
					+ tpc_pkg::PROD_W'(pp_lo_s6[e][k]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s40 <= 1'b0;
		end else if (en) begin
			valid_s1 <= tri_in.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			valid_s40 <= dv_valid[tpc_pkg::DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s1 <= vin;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++) begin
					diff_s1[i][k] <= $signed({vin[i][k][CW-1], vin[i][k]})
						- $signed({plane_q[k][CW-1], plane_q[k]});
					prod_s2[i][k] <= diff_s1[i][k] * normal_q[k];
				end
				d_s3[i] <= prod_s2[i][0] + prod_s2[i][1] + prod_s2[i][2];
			end
			mode_s4 <= mode_c;
			w_s4 <= w_c;
			p2_s4 <= p2_c;
			d1_s4 <= d1_c;
			d2_s4 <= d2_c;
			side_s5 <= side_c;
			for (int e = 0; e < 2; e++) begin
				num_s5[e] <= tpc_pkg::NUM_W'(-d1_s4[e]);
				for (int k = 0; k < 3; k++) begin
					mag_s5[e][k] <= tpc_pkg::MAG_W'(dk_c[e][k][tpc_pkg::DIFF_W-1]
						? -dk_c[e][k] : dk_c[e][k]);
					pp_lo_s6[e][k] <= mag_s5[e][k] * num_s5[e][tpc_pkg::NUM_LO_W-1:0];
					pp_hi_s6[e][k] <= mag_s5[e][k]
						* num_s5[e][tpc_pkg::NUM_W-1:tpc_pkg::NUM_LO_W];
					word_s7.rem[e][k] <= {1'b0, prod_c[e][k][tpc_pkg::PROD_W-1:tpc_pkg::Q_W]};
					word_s7.quo[e][k] <= prod_c[e][k][tpc_pkg::Q_W-1:0];
				end
			end
			side_s6 <= side_s5;
			word_s7.side <= side_s6;
			side_s40 <= fin.side;
			cut_s40 <= cut_c;
		end
	end

	assign dv_valid[0] = valid_s7;
	assign dv_word[0] = word_s7;

	for (genvar g = 0; g < tpc_pkg::DIV_STEPS; g++) begin : g_div
		tpc_div_step u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.up_valid (dv_valid[g]),
			.up_word  (dv_word[g]),
			.dn_valid (dv_valid[g+1]),
			.dn_word  (dv_word[g+1])
		);
	end

	// Cut point: start corner plus or minus the quotient, saturated.
	always_comb begin
		fin = dv_word[tpc_pkg::DIV_STEPS];
		for (int e = 0; e < 2; e++) begin
			for (int k = 0; k < 3; k++) begin
				if (fin.side.neg[e][k]) begin
					csum[e][k] = $signed({{2{fin.side.w[2*e][k][CW-1]}}, fin.side.w[2*e][k]})
						- $signed({2'b00, fin.quo[e][k]});
				end else begin
					csum[e][k] = $signed({{2{fin.side.w[2*e][k][CW-1]}}, fin.side.w[2*e][k]})
						+ $signed({2'b00, fin.quo[e][k]});
				end
				if (csum[e][k][CW+1:CW-1] == 3'b000 || csum[e][k][CW+1:CW-1] == 3'b111) begin
					cut_c[e][k] = csum[e][k][CW-1:0];
				end else if (csum[e][k][CW+1]) begin
					cut_c[e][k] = tpc_pkg::COORD_MIN;
				end else begin
					cut_c[e][k] = tpc_pkg::COORD_MAX;
				end
			end
		end
	end

	// Output stage: holds one clipped result and sends its triangles in turn.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_cnt_q <= 2'd0;
		end else if (en) begin
			out_valid_q <= valid_s40 && (side_s40.mode != tpc_pkg::CLIP_NONE);
			out_cnt_q <= 2'd0;
		end else if (tri_out.ready) begin
			out_cnt_q <= out_cnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_mode_q <= side_s40.mode;
			out_w_q <= side_s40.w;
			out_e_q <= cut_s40;
		end
	end

	always_comb begin
		r0 = out_w_q[0];
		r1 = out_w_q[1];
		r2 = out_w_q[2];
		unique case (out_mode_q)
			tpc_pkg::CLIP_ONE: begin
				r1 = out_e_q[0];
				r2 = out_e_q[1];
			end
			tpc_pkg::CLIP_TWO: begin
				if (out_cnt_q == 2'd0) begin
					r1 = out_e_q[0];
					r2 = out_w_q[1];
				end else if (out_cnt_q == 2'd1) begin
					r0 = out_w_q[1];
					r1 = out_e_q[0];
					r2 = out_e_q[1];
				end else begin
					r0 = out_w_q[1];
					r1 = out_e_q[1];
				end
			end
			default: ;
		endcase
	end

	assign out_last = (out_mode_q != tpc_pkg::CLIP_TWO) || (out_cnt_q == 2'd2);

	assign tri_out.valid = out_valid_q;
	assign tri_out.r0_x = r0[0];
	assign tri_out.r0_y = r0[1];
	assign tri_out.r0_z = r0[2];
	assign tri_out.r1_x = r1[0];
	assign tri_out.r1_y = r1[1];
	assign tri_out.r1_z = r1[2];
	assign tri_out.r2_x = r2[0];
	assign tri_out.r2_y = r2[1];
	assign tri_out.r2_z = r2[2];
	assign tri_out.last_of_run = out_last;

	a_out_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_mode_q != tpc_pkg::CLIP_NONE)
		else $error("Output word shown for a triangle with no inner corner.");

	a_single_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_mode_q != tpc_pkg::CLIP_TWO |-> out_cnt_q == 2'd0)
		else $error("Triangle counter moved for a single-triangle result.");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !tri_out.ready |=> out_valid_q && $stable(out_cnt_q))
		else $error("Output result changed while the word was stalled.");

	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		tri_in.ready |-> !out_valid_q || (tri_out.ready && out_last))
		else $error("Input taken while the output stage still holds triangles.");

endmodule

// ===== bench/triangle_plane_clip_core_tb.sv =====
// ----------------------------------------------------------------------------
// Triangle plane clip core: testbench
// Sends triangles through the clip core under several plane settings and
// checks every clipped triangle word against an in-bench prediction of the
// inside count, edge cuts and midpoints, with random gaps and output stalls.
// ----------------------------------------------------------------------------
module triangle_plane_clip_core_tb;

	localparam logic [tpc_pkg::CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
	localparam logic [tpc_pkg::CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 60;

	typedef logic signed [tpc_pkg::COORD_W-1:0] crd_t;
	typedef struct {
		crd_t c[9];
	} tri_t;
	typedef struct {
		crd_t c[9];
		bit   last;
	} clip_word_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [tpc_pkg::CFG_IDX_W-1:0] cfg_idx;
	logic [tpc_pkg::CFG_DATA_W-1:0] cfg_data;

	tpc_in_if in_ch();
	tpc_out_if out_ch();

	triangle_plane_clip_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.tri_in(in_ch),
		.tri_out(out_ch),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	crd_t plane_pt[3];
	logic signed [tpc_pkg::NORM_W-1:0] plane_n[3];
	clip_word_t clip_expect[$];
	int mismatches = 0;
	int words_checked = 0;
	int tris_sent = 0;
	int reg_writes = 0;
	int inside_hist[4] = '{0, 0, 0, 0};
	int cycles = 0;
	int hold_req = 0;
	bit no_idle = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d words outstanding.", cycles,
				clip_expect.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic crd_t sat32(longint x);
		if (x > 64'sd2147483647)
			return crd_t'(32'h7fff_ffff);
		if (x < -64'sd2147483648)
			return crd_t'(32'h8000_0000);
		return crd_t'(x);
	endfunction

	function automatic longint plane_dist(crd_t p[3]);
		longint s;
		s = 0;
		for (int k = 0; k < 3; k++)
			s += (longint'(p[k]) - longint'(plane_pt[k])) * longint'(plane_n[k]);
		return s;
	endfunction

	function automatic void edge_cut(crd_t p1[3], longint d1, crd_t p2[3], longint d2,
		output crd_t r[3]);
		longint dk;
		logic [63:0] mag;
		logic [127:0] prod;
		logic [127:0] quo;
		for (int k = 0; k < 3; k++) begin
			dk = longint'(p2[k]) - longint'(p1[k]);
			mag = (dk < 0) ? -dk : dk;
			prod = {64'd0, mag} * {64'd0, 64'(-d1)};
			quo = prod / {64'd0, 64'(d2 - d1)};
			if (dk < 0)
				r[k] = sat32(longint'(p1[k]) - longint'(quo[63:0]));
			else
				r[k] = sat32(longint'(p1[k]) + longint'(quo[63:0]));
		end
	endfunction

	function automatic void push_word(crd_t q0[3], crd_t q1[3], crd_t q2[3], bit last);
		clip_word_t w;
		for (int k = 0; k < 3; k++) begin
			w.c[k] = q0[k];
			w.c[3 + k] = q1[k];
			w.c[6 + k] = q2[k];
		end
		w.last = last;
		clip_expect.insert(clip_expect.size(), w);
	endfunction

	function automatic void clip_predict(tri_t t);
		crd_t v[3][3];
		longint d[3];
		int n_in;
		int c_in;
		int c_out;
		int i0;
		int i1;
		crd_t e0[3];
		crd_t e1[3];
		crd_t m[3];
		n_in = 0;
		c_in = 0;
		c_out = 0;
		for (int i = 0; i < 3; i++) begin
			for (int k = 0; k < 3; k++)
				v[i][k] = t.c[i * 3 + k];
			d[i] = plane_dist(v[i]);
			if (d[i] < 0) begin
				c_in = i;
				n_in++;
			end else begin
				c_out = i;
			end
		end
		inside_hist[n_in]++;
		if (n_in == 3) begin
			push_word(v[0], v[1], v[2], 1'b1);
		end else if (n_in == 1) begin
			i0 = (c_in + 1) % 3;
			i1 = (c_in + 2) % 3;
			edge_cut(v[c_in], d[c_in], v[i0], d[i0], e0);
			edge_cut(v[c_in], d[c_in], v[i1], d[i1], e1);
			push_word(v[c_in], e0, e1, 1'b1);
		end else if (n_in == 2) begin
			i0 = (c_out + 2) % 3;
			i1 = (c_out + 1) % 3;
			edge_cut(v[i0], d[i0], v[c_out], d[c_out], e0);
			edge_cut(v[i1], d[i1], v[c_out], d[c_out], e1);
			for (int k = 0; k < 3; k++)
				m[k] = crd_t'((longint'(v[i0][k]) + longint'(v[i1][k])) / 2);
			push_word(v[i0], e0, m, 1'b0);
			push_word(m, e0, e1, 1'b0);
			push_word(m, e1, v[i1], 1'b1);
		end
	endfunction

	task automatic note_mismatch(string what, longint want, longint got);
		mismatches++;
		if (mismatches <= 10)
			$display("Mismatch on %s at cycle %0d: expected %0d, got %0d.", what, cycles,
				want, got);
	endtask

	// Output side: random stalls per word, plus a long hold-off on request.
	int stall_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			stall_left = 0;
		end else if (hold_req > 0) begin
			out_ch.ready <= 1'b0;
			hold_req = hold_req - 1;
		end else if (stall_left > 0) begin
			out_ch.ready <= 1'b0;
			stall_left = stall_left - 1;
		end else if (out_ch.valid && out_ch.ready && !no_idle) begin
			stall_left = $urandom_range(0, 3);
			out_ch.ready <= (stall_left == 0);
			if (stall_left > 0)
				stall_left = stall_left - 1;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		clip_word_t got;
		clip_word_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.c[0] = out_ch.r0_x;
			got.c[1] = out_ch.r0_y;
			got.c[2] = out_ch.r0_z;
			got.c[3] = out_ch.r1_x;
			got.c[4] = out_ch.r1_y;
			got.c[5] = out_ch.r1_z;
			got.c[6] = out_ch.r2_x;
			got.c[7] = out_ch.r2_y;
			got.c[8] = out_ch.r2_z;
			got.last = out_ch.last_of_run;
			if (clip_expect.size() == 0) begin
				note_mismatch("unexpected word, r0_x", 0, got.c[0]);
			end else begin
				want = clip_expect.pop_front();
				words_checked++;
				for (int k = 0; k < 9; k++)
					if (got.c[k] !== want.c[k])
						note_mismatch($sformatf("r%0d_%s", k / 3, (k % 3 == 0) ? "x" :
							(k % 3 == 1) ? "y" : "z"), want.c[k], got.c[k]);
				if (got.last !== want.last)
					note_mismatch("last_of_run", want.last, got.last);
			end
		end
	end

	// Called just after a rising edge; returns at the accepting edge with valid high.
	task automatic send_tri(tri_t t);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.a_x <= t.c[0];
		in_ch.a_y <= t.c[1];
		in_ch.a_z <= t.c[2];
		in_ch.b_x <= t.c[3];
		in_ch.b_y <= t.c[4];
		in_ch.b_z <= t.c[5];
		in_ch.c_x <= t.c[6];
		in_ch.c_y <= t.c[7];
		in_ch.c_z <= t.c[8];
		in_ch.valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ch.ready);
		clip_predict(t);
		tris_sent++;
	endtask

	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		while (clip_expect.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [tpc_pkg::CFG_IDX_W-1:0] idx,
		logic [tpc_pkg::CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		reg_writes++;
		case (idx)
			tpc_pkg::CFG_PLANE_PX: plane_pt[0] = data;
			tpc_pkg::CFG_PLANE_PY: plane_pt[1] = data;
			tpc_pkg::CFG_PLANE_PZ: plane_pt[2] = data;
			tpc_pkg::CFG_NORMAL_X: plane_n[0] = data[tpc_pkg::NORM_W-1:0];
			tpc_pkg::CFG_NORMAL_Y: plane_n[1] = data[tpc_pkg::NORM_W-1:0];
			tpc_pkg::CFG_NORMAL_Z: plane_n[2] = data[tpc_pkg::NORM_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_plane(crd_t px, crd_t py, crd_t pz, int nx, int ny, int nz);
		write_reg(tpc_pkg::CFG_PLANE_PX, px);
		write_reg(tpc_pkg::CFG_PLANE_PY, py);
		write_reg(tpc_pkg::CFG_PLANE_PZ, pz);
		write_reg(tpc_pkg::CFG_NORMAL_X, nx);
		write_reg(tpc_pkg::CFG_NORMAL_Y, ny);
		write_reg(tpc_pkg::CFG_NORMAL_Z, nz);
	endtask

	function automatic tri_t make_tri(int ax, int ay, int az, int bx, int by, int bz,
		int cx, int cy, int cz);
		tri_t t;
		t.c = '{ax, ay, az, bx, by, bz, cx, cy, cz};
		return t;
	endfunction

	function automatic crd_t wild_coord();
		case ($urandom_range(0, 3))
			0: return crd_t'($urandom);
			1: return crd_t'(int'($urandom_range(0, 2097151)) - 1048576);
			2: return ($urandom_range(0, 1)) ? crd_t'(32'h7fff_ffff) : crd_t'(32'h8000_0000);
			default: return crd_t'(int'($urandom_range(0, 255)) - 128);
		endcase
	endfunction

	// Mostly triangles straddling the plane point, some anywhere.
	function automatic tri_t rand_tri();
		tri_t t;
		int sh;
		longint span;
		sh = $urandom_range(4, 26);
		span = longint'(1) << sh;
		for (int k = 0; k < 9; k++)
			if ($urandom_range(0, 9) < 7)
				t.c[k] = sat32(longint'(plane_pt[k % 3]) +
					longint'($urandom_range(0, 2 * span)) - span);
			else
				t.c[k] = wild_coord();
		return t;
	endfunction

	function automatic int rand_normal();
		case ($urandom_range(0, 5))
			0: return ($urandom_range(0, 1)) ? 65536 : -65536;
			1: return 0;
			2: return int'($urandom);
			default: return int'($urandom_range(0, 92000)) - 46000;
		endcase
	endfunction

	function automatic crd_t rand_point();
		if ($urandom_range(0, 4) == 0)
			return wild_coord();
		return crd_t'(int'($urandom_range(0, 33554431)) - 16777216);
	endfunction

	task automatic test_reset_plane();
		tri_t dir[$];
		dir.insert(dir.size(), make_tri(1, 2, -1, 3, 4, -2, 5, 6, -3));
		dir.insert(dir.size(), make_tri(1, 2, 1, 3, 4, 2, 5, 6, 3));
		dir.insert(dir.size(), make_tri(7, 7, 0, 8, 8, 0, 9, 9, 0));
		dir.insert(dir.size(), make_tri(0, 0, 0, 100, 0, 0, 0, 100, -5));
		dir.insert(dir.size(), make_tri(0, 0, -65536, 65536, 0, 65536, 0, 65536, 131072));
		dir.insert(dir.size(), make_tri(0, 0, 65536, 65536, 0, -65536, 0, 65536, 131072));
		dir.insert(dir.size(), make_tri(0, 0, 65536, 65536, 0, 131072, 0, 65536, -65536));
		dir.insert(dir.size(), make_tri(-3, 5, -65536, 0, -7, -1, 40, 40, 65536));
		dir.insert(dir.size(), make_tri(-3, 5, 65536, 0, -7, -1, 40, 40, -65536));
		dir.insert(dir.size(), make_tri(-3, 5, -1, 0, -7, 65536, 40, 40, -65536));
		dir.insert(dir.size(), make_tri(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
			32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0, 0, -1));
		dir.insert(dir.size(), make_tri(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, -1, -1, 32'h7fff_ffff));
		dir.insert(dir.size(), make_tri(-1, -1, -1, -1, -1, -1, -1, -1, -1));
		foreach (dir[i])
			send_tri(dir[i]);
		wait_idle();
	endtask

	task automatic test_plane_registers();
		set_plane(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, -65536, 65536, -65536);
		send_tri(make_tri(0, 0, 0, 32'h7fff_ffff, 0, 0, 0, 32'h8000_0000, 0));
		send_tri(make_tri(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
			32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 5, 5, 5));
		wait_idle();
		// A zero normal puts every corner on the plane.
		set_plane(0, 0, 0, 0, 0, 0);
		send_tri(make_tri(-9, -9, -9, 1, 1, 1, 32'h8000_0000, 0, 0));
		wait_idle();
		// Extreme normals, one out of range and kept as its low 18 bits; spare indexes do nothing.
		set_plane(100, -100, 0, 131071, -131072, 32'hfffc_0001);
		write_reg(CFG_SPARE_6, 32'hdead_beef);
		write_reg(CFG_SPARE_7, 32'h1234_5678);
		send_tri(make_tri(-50000, 0, 0, 50000, 0, 0, 0, 50000, -70000));
		send_tri(make_tri(99, -101, 3, 200, 10, -3, -7, 0, 0));
		wait_idle();
	endtask

	task automatic test_random_planes(int phases, int per_phase);
		for (int p = 0; p < phases; p++) begin
			set_plane(rand_point(), rand_point(), rand_point(), rand_normal(), rand_normal(),
				rand_normal());
			no_idle = (p % 4 == 3);
			for (int i = 0; i < per_phase; i++)
				send_tri(rand_tri());
			wait_idle();
		end
		no_idle = 1'b0;
	endtask

	task automatic test_output_hold();
		set_plane(0, 0, 0, 0, 0, 65536);
		hold_req = 300;
		for (int i = 0; i < 50; i++)
			send_tri(rand_tri());
		wait_idle();
	endtask

	task automatic test_drain_pause();
		set_plane(rand_point(), rand_point(), rand_point(), 0, -65536, 0);
		for (int i = 0; i < 20; i++)
			send_tri(rand_tri());
		in_ch.valid <= 1'b0;
		while (clip_expect.size() != 0)
			@(posedge clk);
		for (int i = 0; i < 20; i++)
			send_tri(rand_tri());
		wait_idle();
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_idx <= tpc_pkg::CFG_PLANE_PX;
		cfg_data <= '0;
		in_ch.valid <= 1'b0;
		in_ch.a_x <= '0;
		in_ch.a_y <= '0;
		in_ch.a_z <= '0;
		in_ch.b_x <= '0;
		in_ch.b_y <= '0;
		in_ch.b_z <= '0;
		in_ch.c_x <= '0;
		in_ch.c_y <= '0;
		in_ch.c_z <= '0;
		plane_pt = '{0, 0, 0};
		plane_n = '{0, 0, tpc_pkg::NORMAL_Z_RST};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_plane();
		test_plane_registers();
		test_random_planes(8, 45);
		test_output_hold();
		test_drain_pause();
		$display("Sent %0d triangles with 0/1/2/3 corners inside: %0d/%0d/%0d/%0d.",
			tris_sent, inside_hist[0], inside_hist[1], inside_hist[2], inside_hist[3]);
		$display("Checked %0d words over %0d register writes, %0d mismatches.",
			words_checked, reg_writes, mismatches);
		if (mismatches == 0 && clip_expect.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/tpc_pkg.sv
sv/tpc_in_if.sv
sv/tpc_out_if.sv
sv/tpc_div_step.sv
sv/triangle_plane_clip_core.sv
bench/triangle_plane_clip_core_tb.sv
